// File: sv/fsc_pkg.sv
// shared constants, types and sine table for the fourier series coefficient block
package fsc_pkg;

	localparam int MAX_SAMPLES      = 1024;
	localparam int MAX_HARMONICS    = 64;
	localparam int ANGLE_TABLE_BITS = 10;

	localparam int ADDR_W  = $clog2(MAX_SAMPLES);
	localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int QUARTER = 1 << ANGLE_TABLE_BITS;
	localparam int ROM_W   = ANGLE_TABLE_BITS + 1;
	localparam int HCNT_W  = 7;
	localparam int HIDX_W  = 6;
	localparam int ACC_W   = 48;
	localparam int WS_W    = 35;
	localparam int TRIG_W  = 33;
	localparam int PROD_W  = WS_W + TRIG_W;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint      ONE_Q30     = 64'sd1073741824;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_HARMONIC_COUNT = 2'd0;
	localparam reg_index_t REG_PHASE_ORIGIN   = 2'd1;
	localparam reg_index_t REG_PHASE_STEP     = 2'd2;
	localparam reg_index_t REG_SUM_WEIGHT     = 2'd3;

	typedef logic [30:0] qsine_t [0:QUARTER];

	function automatic logic [30:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0) sum = 0;
		if (sum > ONE_Q30) sum = ONE_Q30;
		return sum[30:0];
	endfunction

	function automatic qsine_t build_qsine();
		qsine_t t;
		for (int k = 0; k <= QUARTER; k++) begin
			t[k] = sine_q30((64'(k) * HALF_PI_Q30) >> ANGLE_TABLE_BITS);
		end
		return t;
	endfunction

	localparam qsine_t QSINE = build_qsine();

endpackage

// File: sv/fsc_ram.sv
// generic single write port ram with registered read
module fsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: sv/fourier_series_coefficients.sv
// top level of the fourier series coefficient block
//
// samples enter as command transactions: one is taken at a clock edge with
// start high and busy low. for a sample without last_sample busy stays low, so
// samples load one per cycle into the sample store. samples beyond the store
// capacity are discarded and flagged. the sample marked last starts the run:
// busy goes high and, for each harmonic n, the block walks the stored samples
// through one shared multiplier, a sample at a time (store read, two weighting
// and four trig products, final accumulate). each harmonic result is shown for
// one cycle with done high; the receiver cannot stall and must take it then.
// last_harmonic marks the final result, shown with busy already low and the
// store empty again. configuration writes through wr_en, wr_index, wr_data are
// taken at once and belong to idle periods.
// reset clears the sample count, overflow flag and sequencer and loads the
// register reset values; store contents are not cleared.
module fourier_series_coefficients (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  fsc_pkg::reg_index_t  wr_index,
	input  logic [31:0]          wr_data,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   sample_y,
	input  logic signed [31:0]   sample_z,
	input  logic                 last_sample,
	output logic                 done,
	output logic [5:0]           harmonic_index,
	output logic signed [31:0]   cos_coef_y,
	output logic signed [31:0]   cos_coef_z,
	output logic signed [31:0]   sin_coef_y,
	output logic signed [31:0]   sin_coef_z,
	output logic                 samples_dropped,
	output logic                 last_harmonic
);
	import fsc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_HSTART, S_RD, S_MWY, S_MWZ, S_M0, S_M1, S_M2, S_M3, S_ACC, S_EMIT
	} state_t;

	state_t state_q;

	logic [HCNT_W-1:0]  hcount_q;
	logic [31:0]        origin_q, step_q, weight_q;
	logic [COUNT_W-1:0] count_q, i_q;
	logic               ovf_q;
	logic [HCNT_W-1:0]  cnt_q;
	logic [HIDX_W-1:0]  n_q;
	logic [31:0]        h_ang_q, h_dn_q, ang_q;
	logic [30:0]        a_q, rom_q;
	logic signed [TRIG_W-1:0] s_q, c_q, s_d, c_d;
	logic signed [WS_W-1:0]   wy_q, wz_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [WS_W-1:0]   mul_a;
	logic signed [TRIG_W-1:0] mul_b;
	logic signed [ACC_W-1:0]  acc_q [0:3];
	logic [ROM_W-1:0]   rom_addr;
	logic [63:0]        rdata;
	logic               ram_we;
	logic [1:0]         acc_sel;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_new;
	logic signed [WS_W-1:0]   term;
	logic [HCNT_W-1:0]  cnt_clamp;

	assign busy   = (state_q != S_IDLE);
	assign ram_we = start && !busy && (count_q < COUNT_W'(MAX_SAMPLES));

	fsc_ram #(.WIDTH(64), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({sample_y, sample_z}),
		.raddr (i_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// quarter wave table, registered read
	always_comb begin
		if (state_q == S_MWY) begin
			rom_addr = ROM_W'(QUARTER) - {1'b0, ang_q[29 -: ANGLE_TABLE_BITS]};
		end else begin
			rom_addr = {1'b0, ang_q[29 -: ANGLE_TABLE_BITS]};
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= QSINE[rom_addr];
	end

	always_comb begin
		case (ang_q[31:30])
			2'd0: begin s_d = TRIG_W'(a_q);  c_d = TRIG_W'(rom_q); end
			2'd1: begin s_d = TRIG_W'(rom_q); c_d = -TRIG_W'(a_q); end
			2'd2: begin s_d = -TRIG_W'(a_q); c_d = -TRIG_W'(rom_q); end
			default: begin s_d = -TRIG_W'(rom_q); c_d = TRIG_W'(a_q); end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_MWY: begin mul_a = WS_W'(signed'(rdata[63:32])); mul_b = {1'b0, weight_q}; end
			S_MWZ: begin mul_a = WS_W'(signed'(rdata[31:0]));  mul_b = {1'b0, weight_q}; end
			S_M0:  begin mul_a = wy_q; mul_b = c_q; end
			S_M1:  begin mul_a = wz_q; mul_b = c_q; end
			S_M2:  begin mul_a = wy_q; mul_b = s_q; end
			S_M3:  begin mul_a = wz_q; mul_b = s_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// saturating accumulate of the product from the previous cycle
	always_comb begin
		case (state_q)
			S_M1:    acc_sel = 2'd0;
			S_M2:    acc_sel = 2'd1;
			S_M3:    acc_sel = 2'd2;
			default: acc_sel = 2'd3;
		endcase
		term    = prod_q[64:30];
		acc_sum = (ACC_W+1)'(acc_q[acc_sel]) + (ACC_W+1)'(term);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_new = acc_sum[ACC_W-1:0];
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > ACC_W'(signed'(32'h7fffffff))) return 32'h7fffffff;
		if (v < ACC_W'(signed'(32'h80000000))) return 32'h80000000;
		return v[31:0];
	endfunction

	always_comb begin
		cnt_clamp = hcount_q;
		if (hcount_q == '0) cnt_clamp = HCNT_W'(1);
		if (hcount_q > HCNT_W'(MAX_HARMONICS)) cnt_clamp = HCNT_W'(MAX_HARMONICS);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcount_q <= HCNT_W'(8);
			origin_q <= '0;
			step_q   <= '0;
			weight_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_HARMONIC_COUNT: hcount_q <= wr_data[HCNT_W-1:0];
				REG_PHASE_ORIGIN:   origin_q <= wr_data;
				REG_PHASE_STEP:     step_q   <= wr_data;
				REG_SUM_WEIGHT:     weight_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			ovf_q           <= 1'b0;
			done            <= 1'b0;
			i_q             <= '0;
			n_q             <= '0;
			cnt_q           <= '0;
			h_ang_q         <= '0;
			h_dn_q          <= '0;
			ang_q           <= '0;
			a_q             <= '0;
			wy_q            <= '0;
			wz_q            <= '0;
			s_q             <= '0;
			c_q             <= '0;
			for (int j = 0; j < 4; j++) acc_q[j] <= '0;
			harmonic_index  <= '0;
			cos_coef_y      <= '0;
			cos_coef_z      <= '0;
			sin_coef_y      <= '0;
			sin_coef_z      <= '0;
			samples_dropped <= 1'b0;
			last_harmonic   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (ram_we) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
						if (last_sample) begin
							cnt_q   <= cnt_clamp;
							n_q     <= '0;
							h_ang_q <= '0;
							h_dn_q  <= '0;
							state_q <= S_HSTART;
						end
					end
				end
				S_HSTART: begin
					for (int j = 0; j < 4; j++) acc_q[j] <= '0;
					ang_q   <= h_ang_q;
					i_q     <= '0;
					state_q <= (count_q == '0) ? S_EMIT : S_RD;
				end
				S_RD: state_q <= S_MWY;
				S_MWY: begin
					a_q     <= rom_q;
					state_q <= S_MWZ;
				end
				S_MWZ: begin
					wy_q    <= prod_q[64:30];
					s_q     <= s_d;
					c_q     <= c_d;
					state_q <= S_M0;
				end
				S_M0: begin
					wz_q    <= prod_q[64:30];
					state_q <= S_M1;
				end
				S_M1: begin
					acc_q[acc_sel] <= acc_new;
					state_q <= S_M2;
				end
				S_M2: begin
					acc_q[acc_sel] <= acc_new;
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q[acc_sel] <= acc_new;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q[acc_sel] <= acc_new;
					ang_q <= ang_q + h_dn_q;
					i_q   <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == count_q) ? S_EMIT : S_RD;
				end
				S_EMIT: begin
					done            <= 1'b1;
					harmonic_index  <= n_q;
					cos_coef_y      <= sat32(acc_q[0]);
					cos_coef_z      <= sat32(acc_q[1]);
					sin_coef_y      <= sat32(acc_q[2]);
					sin_coef_z      <= sat32(acc_q[3]);
					samples_dropped <= ovf_q;
					last_harmonic   <= ({1'b0, n_q} + 1'b1 == cnt_q);
					n_q     <= n_q + 1'b1;
					h_ang_q <= h_ang_q + origin_q;
					h_dn_q  <= h_dn_q + step_q;
					if ({1'b0, n_q} + 1'b1 == cnt_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HSTART;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/fsc_checker.sv
// port level checks for the fourier series coefficient block, with bind
module fsc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_sample,
	input logic done,
	input logic last_harmonic
);
	a_done_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result outside a run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_harmonic |-> !busy) else $error("busy after final harmonic");

	a_plain_sample: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_sample |=> !busy && !done)
		else $error("plain sample caused activity");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_sample |=> busy) else $error("run did not start");
endmodule

bind fourier_series_coefficients fsc_checker u_fsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.last_sample   (last_sample),
	.done          (done),
	.last_harmonic (last_harmonic)
);

// File: tb/tb_top.sv
// self-checking testbench for the fourier series coefficient block
module tb_top;
	import fsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 50000;
	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;

	typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		reg_index_t          idx;
		logic [31:0]         val;
		logic signed [31:0]  y, z;
		logic                last;
		logic signed [31:0]  ecy, ecz, esy, esz;
	} stim_row_t;

	typedef struct {
		logic [5:0]          idx;
		logic signed [31:0]  cy, cz, sy, sz;
		logic                drop, lastf;
	} coef_set_t;

	logic clk, arst_n, wr_en, start, busy, last_sample, done;
	reg_index_t wr_index;
	logic [31:0] wr_data;
	logic signed [31:0] sample_y, sample_z;
	logic [5:0] harmonic_index;
	logic signed [31:0] cos_coef_y, cos_coef_z, sin_coef_y, sin_coef_z;
	logic samples_dropped, last_harmonic;

	fourier_series_coefficients i_dut (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// predictor state
	longint             sine_tab [0:QUARTER];
	logic signed [31:0] y_mem [0:MAX_SAMPLES-1];
	logic signed [31:0] z_mem [0:MAX_SAMPLES-1];
	int                 held;
	logic               dropped;
	logic [6:0]         hcount;
	logic [31:0]        origin, step, weight;
	coef_set_t          coef_q [$];
	logic               known_mode;
	logic signed [31:0] known_cy, known_cz, known_sy, known_sz;

	int errors, accepted, checked, runs, idle_pct, idle_cycles;

	function automatic longint quarter_sine(longint unsigned x);
		longint unsigned x2, term;
		longint acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int j = 1; j <= 7; j++) begin
			term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
			if (j % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sd1073741824) acc = 64'sd1073741824;
		return acc;
	endfunction

	function automatic longint acc_sat(longint a, longint t);
		longint v;
		v = a + t;
		if (v > ACC_HI) v = ACC_HI;
		if (v < ACC_LO) v = ACC_LO;
		return v;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic int harmonics_used();
		if (hcount == 0) return 1;
		if (hcount > MAX_HARMONICS) return MAX_HARMONICS;
		return hcount;
	endfunction

	function automatic void predict_coefs();
		longint acc [4];
		longint wy, wz, s, c, a, b;
		logic [31:0] ph, ang;
		coef_set_t r;
		int cnt;
		cnt = harmonics_used();
		for (int n = 0; n < cnt; n++) begin
			acc = '{0, 0, 0, 0};
			ph = origin;
			for (int i = 0; i < held; i++) begin
				wy = (longint'(y_mem[i]) * longint'({32'b0, weight})) >>> 30;
				wz = (longint'(z_mem[i]) * longint'({32'b0, weight})) >>> 30;
				ang = 32'(n) * ph;
				a = sine_tab[ang[29:20]];
				b = sine_tab[QUARTER - int'(ang[29:20])];
				case (ang[31:30])
					2'd0: begin s = a; c = b; end
					2'd1: begin s = b; c = -a; end
					2'd2: begin s = -a; c = -b; end
					default: begin s = -b; c = a; end
				endcase
				acc[0] = acc_sat(acc[0], (wy * c) >>> 30);
				acc[1] = acc_sat(acc[1], (wz * c) >>> 30);
				acc[2] = acc_sat(acc[2], (wy * s) >>> 30);
				acc[3] = acc_sat(acc[3], (wz * s) >>> 30);
				ph = ph + step;
			end
			r.idx = n[5:0];
			if (known_mode) begin
				r.cy = known_cy; r.cz = known_cz; r.sy = known_sy; r.sz = known_sz;
			end else begin
				r.cy = clip32(acc[0]); r.cz = clip32(acc[1]);
				r.sy = clip32(acc[2]); r.sz = clip32(acc[3]);
			end
			r.drop = dropped;
			r.lastf = (n == cnt - 1);
			coef_q.push_back(r);
		end
		held = 0;
		dropped = 1'b0;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// monitor: register mirror, sample capture and result check
	always @(posedge clk) begin : monitor
		coef_set_t e;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_HARMONIC_COUNT: hcount = wr_data[6:0];
					REG_PHASE_ORIGIN: origin = wr_data;
					REG_PHASE_STEP: step = wr_data;
					REG_SUM_WEIGHT: weight = wr_data;
					default: ;
				endcase
			end
			if (done) begin
				if (coef_q.size() == 0) begin
					$display("%0t unexpected result transaction, index %0d",
						$realtime, harmonic_index);
					errors++;
				end else begin
					e = coef_q.pop_front();
					checked++;
					if (harmonic_index !== e.idx) report("harmonic_index", harmonic_index, e.idx);
					if (cos_coef_y !== e.cy) report("cos_coef_y", cos_coef_y, e.cy);
					if (cos_coef_z !== e.cz) report("cos_coef_z", cos_coef_z, e.cz);
					if (sin_coef_y !== e.sy) report("sin_coef_y", sin_coef_y, e.sy);
					if (sin_coef_z !== e.sz) report("sin_coef_z", sin_coef_z, e.sz);
					if (samples_dropped !== e.drop)
						report("samples_dropped", samples_dropped, e.drop);
					if (last_harmonic !== e.lastf)
						report("last_harmonic", last_harmonic, e.lastf);
				end
			end
			if (start && !busy) begin
				accepted++;
				if (held < MAX_SAMPLES) begin
					y_mem[held] = sample_y;
					z_mem[held] = sample_z;
					held++;
				end else begin
					dropped = 1'b1;
				end
				if (last_sample) begin
					runs++;
					predict_coefs();
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_index_t i, logic [31:0] v);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= i;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send(logic signed [31:0] y, logic signed [31:0] z, logic l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		sample_y <= y;
		sample_z <= z;
		last_sample <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (coef_q.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(2097152)) - 1048576);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_reg();
		case ($urandom_range(4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h4000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'd64;
			2: return 32'd127;
			3: return 32'($urandom_range(127));
			default: return 32'($urandom_range(8, 1));
		endcase
	endfunction

	stim_row_t directed [] = '{
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0},
		'{ROW_KNOWN, REG_HARMONIC_COUNT, 0, 32'sh0001_0000, -32'sh0001_0000, 1, 0, 0, 0, 0},
		'{ROW_CFG, REG_HARMONIC_COUNT, 32'd1, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SUM_WEIGHT, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_KNOWN, REG_HARMONIC_COUNT, 0, 32'sh0001_0000, -32'sh0002_0000, 1,
			32'sh0001_0000, -32'sh0002_0000, 0, 0},
		'{ROW_CFG, REG_HARMONIC_COUNT, 32'd0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_PHASE_STEP, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh0003_0000, 32'sh0000_8000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, -32'sh0001_0000, 32'sh0001_0000, 1, 0, 0, 0, 0},
		'{ROW_CFG, REG_HARMONIC_COUNT, 32'd127, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_PHASE_ORIGIN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_PHASE_STEP, 32'h0123_4567, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SUM_WEIGHT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 0, 0, 0},
		'{ROW_CFG, REG_HARMONIC_COUNT, 32'd64, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, REG_HARMONIC_COUNT, 0, 32'sh8000_0000, 32'sh0000_0001, 1, 0, 0, 0, 0}
	};

	initial begin
		int nsamp;
		for (int k = 0; k <= QUARTER; k++)
			sine_tab[k] = quarter_sine((longint'(k) * 64'd1686629713) >> ANGLE_TABLE_BITS);
		held = 0; dropped = 1'b0; hcount = 7'd8;
		origin = 0; step = 0; weight = 0;
		known_mode = 1'b0;
		known_cy = 0; known_cz = 0; known_sy = 0; known_sz = 0;
		errors = 0; accepted = 0; checked = 0; runs = 0; idle_pct = 0; idle_cycles = 0;
		arst_n = 1'b0; wr_en = 1'b0; wr_index = REG_HARMONIC_COUNT; wr_data = '0;
		start = 1'b0; sample_y = '0; sample_z = '0; last_sample = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[r]) begin
			if (directed[r].kind == ROW_CFG) begin
				settle();
				write_reg(directed[r].idx, directed[r].val);
			end else begin
				known_mode = (directed[r].kind == ROW_KNOWN);
				known_cy = directed[r].ecy; known_cz = directed[r].ecz;
				known_sy = directed[r].esy; known_sz = directed[r].esz;
				send(directed[r].y, directed[r].z, directed[r].last);
				if (directed[r].last) settle();
				known_mode = 1'b0;
			end
		end

		// random runs, cycling through sender idling phases
		while (accepted < 280) begin
			case (runs % 4)
				0: idle_pct = 0;
				1: idle_pct = 46;
				default: idle_pct = 20;
			endcase
			settle();
			if ($urandom_range(2) == 0) write_reg(REG_HARMONIC_COUNT, pick_count());
			if ($urandom_range(2) == 0) write_reg(REG_PHASE_ORIGIN, pick_reg());
			if ($urandom_range(2) == 0) write_reg(REG_PHASE_STEP, pick_reg());
			if ($urandom_range(2) == 0) write_reg(REG_SUM_WEIGHT, pick_reg());
			nsamp = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			for (int i = 0; i < nsamp; i++)
				send(pick_value(), pick_value(), i == nsamp - 1);
		end

		// store overflow: more samples than the store holds
		settle();
		idle_pct = 0;
		write_reg(REG_HARMONIC_COUNT, 32'd2);
		for (int i = 0; i < MAX_SAMPLES + 6; i++)
			send(pick_value(), pick_value(), i == MAX_SAMPLES + 5);
		settle();

		$display("%0d sample transactions in %0d runs, %0d harmonic results checked",
			accepted, runs, checked);
		$display("covered register extremes, idling phases and store overflow");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
sv/fsc_pkg.sv
sv/fsc_ram.sv
sv/fourier_series_coefficients.sv
sv/fsc_checker.sv
tb/tb_top.sv
